// ===== hdl/lhp_pkg.sv =====
// shared codes, constants and record types for the link/ip/transport header parser
package lhp_pkg;

    typedef enum logic [1:0] {
        LINK_COOKED   = 2'd0,
        LINK_ETHERNET = 2'd1,
        LINK_RAW_IPV4 = 2'd2,
        LINK_RAW_IPV6 = 2'd3
    } link_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_NOT_IP    = 2'd2,
        ST_NOT_L4    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_SRC    = 2'd1,
        KIND_DST    = 2'd2
    } kind_t;

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [7:0]  COOKED_HDR_LEN = 8'd16;
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [7:0]  IPV6_HDR_LEN   = 8'd40;
    localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
    localparam logic [15:0] COUNT_MAX      = 16'hffff;

    // everything needed to replay one frame's result items
    typedef struct packed {
        status_t            status;
        logic               v6;
        logic [7:0]         proto;
        logic [15:0]        sport;
        logic [15:0]        dport;
        logic [7:0]         pay;
        logic [3:0][31:0]   src;
        logic [3:0][31:0]   dst;
    } frame_rec_t;

endpackage

// ===== hdl/link_ip_transport_header_parser.sv =====
// link/ip/transport header parser: byte stream in, status and address items out
// latency: the status item is offered the cycle after the frame's last byte is accepted
// throughput: one byte per cycle; one item per unstalled cycle (1, 3 or 9 per frame)
// a final byte is stalled only while the previous frame's items are still draining
// header tracking is a single pass over the byte counter and per-frame registers
// reset clears all frame state and the result queue; link_kind resets to ethernet
module link_ip_transport_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  word_index,
    output logic [1:0]  status,
    output logic        ip_version,
    output logic [7:0]  proto_num,
    output logic [15:0] source_port,
    output logic [15:0] dst_port,
    output logic [7:0]  pay_offset,
    output logic [31:0] addr_word,
    output logic        last_result
);

    logic [1:0]        link_kind_reg;
    logic [15:0]       byte_count_reg, byte_count_next;
    logic [15:0]       net_type_reg, net_type_next;
    logic [7:0]        net_start_reg, net_start_next;
    logic [7:0]        transport_start_reg, transport_start_next;
    logic [7:0]        payload_start_reg, payload_start_next;
    logic [7:0]        next_proto_reg, next_proto_next;
    logic [15:0]       port_src_reg, port_src_next;
    logic [15:0]       port_dst_reg, port_dst_next;
    logic [3:0][31:0]  src_words_reg, src_words_next;
    logic [3:0][31:0]  dst_words_reg, dst_words_next;

    lhp_pkg::frame_rec_t snap_reg, snap_next;
    logic              busy_reg, busy_next;
    logic [3:0]        seq_reg, seq_next;

    logic              in_acc, out_acc, first;
    logic [15:0]       p, rel, tr, v6_src_rel, v6_dst_rel;
    logic [16:0]       len;
    logic              is_ip, v6_now;
    logic [7:0]        pay;
    lhp_pkg::status_t  st;
    logic [3:0]        n_words, addr_seq, dst_seq;
    logic [1:0]        idx;

    assign p       = byte_count_reg;
    assign first   = (byte_count_reg == 16'd0);
    assign out_acc = busy_reg && !out_stall;
    // a final byte waits until the queued frame has handed over its last item
    assign in_stall = frame_end && busy_reg && !(out_acc && last_result);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        net_start_next       = first ? 8'd0 : net_start_reg;
        net_type_next        = first ? 16'd0 : net_type_reg;
        transport_start_next = first ? 8'd0 : transport_start_reg;
        payload_start_next   = first ? 8'd0 : payload_start_reg;
        next_proto_next      = first ? 8'd0 : next_proto_reg;
        port_src_next        = first ? 16'd0 : port_src_reg;
        port_dst_next        = first ? 16'd0 : port_dst_reg;
        src_words_next       = first ? '0 : src_words_reg;
        dst_words_next       = first ? '0 : dst_words_reg;
        tr                   = 16'd0;
        if (first)
        begin
            case (lhp_pkg::link_kind_t'(link_kind_reg))
                lhp_pkg::LINK_COOKED:   net_start_next = lhp_pkg::COOKED_HDR_LEN;
                lhp_pkg::LINK_ETHERNET: net_start_next = lhp_pkg::ETH_HDR_LEN;
                lhp_pkg::LINK_RAW_IPV4: net_type_next  = lhp_pkg::TYPE_IPV4;
                default:                net_type_next  = lhp_pkg::TYPE_IPV6;
            endcase
        end

        // ethertype sits in the two bytes just before the ip header
        if (net_start_next >= 8'd2 &&
            ({1'b0, p} + 17'd2 == {9'd0, net_start_next} ||
             {1'b0, p} + 17'd1 == {9'd0, net_start_next}))
            net_type_next = {net_type_next[7:0], data_byte};

        rel        = p - {8'd0, net_start_next};
        v6_src_rel = rel - 16'd8;
        v6_dst_rel = rel - 16'd24;
        is_ip = (net_type_next == lhp_pkg::TYPE_IPV4) || (net_type_next == lhp_pkg::TYPE_IPV6);

        if (p >= {8'd0, net_start_next} && is_ip)
        begin
            if (net_type_next == lhp_pkg::TYPE_IPV4)
            begin
                if (rel == 16'd0)
                    transport_start_next = net_start_next + {2'd0, data_byte[3:0], 2'd0};
                if (rel == 16'd9)
                    next_proto_next = data_byte;
                if (rel >= 16'd12 && rel < 16'd16)
                    src_words_next[0] = {src_words_next[0][23:0], data_byte};
                if (rel >= 16'd16 && rel < 16'd20)
                    dst_words_next[0] = {dst_words_next[0][23:0], data_byte};
            end
            else
            begin
                if (rel == 16'd0)
                    transport_start_next = net_start_next + lhp_pkg::IPV6_HDR_LEN;
                if (rel == 16'd6)
                    next_proto_next = data_byte;
                if (rel >= 16'd8 && rel < 16'd24)
                    src_words_next[v6_src_rel[3:2]] =
                        {src_words_next[v6_src_rel[3:2]][23:0], data_byte};
                if (rel >= 16'd24 && rel < 16'd40)
                    dst_words_next[v6_dst_rel[3:2]] =
                        {dst_words_next[v6_dst_rel[3:2]][23:0], data_byte};
            end
            tr = p - {8'd0, transport_start_next};
            if (p >= {8'd0, transport_start_next})
            begin
                if (tr < 16'd2)
                    port_src_next = {port_src_next[7:0], data_byte};
                else if (tr < 16'd4)
                    port_dst_next = {port_dst_next[7:0], data_byte};
                else if (tr == 16'd12)
                    payload_start_next = {2'd0, data_byte[7:4], 2'd0};
            end
        end

        if (frame_end)
            byte_count_next = 16'd0;
        else if (byte_count_reg < lhp_pkg::COUNT_MAX)
            byte_count_next = byte_count_reg + 16'd1;
        else
            byte_count_next = byte_count_reg;
    end

    // end-of-frame checks on the values that include the final byte
    assign len    = {1'b0, p} + 17'd1;
    assign v6_now = (net_type_next == lhp_pkg::TYPE_IPV6);
    assign pay    = transport_start_next +
                    ((next_proto_next == lhp_pkg::PROTO_UDP) ? lhp_pkg::UDP_HDR_LEN
                                                             : payload_start_next);

    always_comb
    begin
        if ({9'd0, net_start_next} >= len)
            st = lhp_pkg::ST_TOO_SHORT;
        else if (!is_ip)
            st = lhp_pkg::ST_NOT_IP;
        else if ({9'd0, transport_start_next} >= len)
            st = lhp_pkg::ST_TOO_SHORT;
        else if (next_proto_next != lhp_pkg::PROTO_UDP && next_proto_next != lhp_pkg::PROTO_TCP)
            st = lhp_pkg::ST_NOT_L4;
        else if ({9'd0, pay} >= len)
            st = lhp_pkg::ST_TOO_SHORT;
        else
            st = lhp_pkg::ST_OK;

        snap_next        = '0;
        snap_next.status = st;
        if (st == lhp_pkg::ST_OK)
        begin
            snap_next.v6    = v6_now;
            snap_next.proto = next_proto_next;
            snap_next.sport = port_src_next;
            snap_next.dport = port_dst_next;
            snap_next.pay   = pay;
            snap_next.src   = src_words_next;
            snap_next.dst   = dst_words_next;
        end
    end

    // result sequencing: status, then for an ok frame source words, then destination words
    assign n_words  = snap_reg.v6 ? 4'd4 : 4'd1;
    assign addr_seq = seq_reg - 4'd1;
    assign dst_seq  = addr_seq - n_words;

    always_comb
    begin
        kind        = lhp_pkg::KIND_STATUS;
        word_index  = 2'd0;
        status      = lhp_pkg::ST_OK;
        ip_version  = 1'b0;
        proto_num   = 8'd0;
        source_port = 16'd0;
        dst_port    = 16'd0;
        pay_offset  = 8'd0;
        addr_word   = 32'd0;
        last_result = 1'b0;
        idx         = 2'd0;
        if (seq_reg == 4'd0)
        begin
            status      = snap_reg.status;
            ip_version  = snap_reg.v6;
            proto_num   = snap_reg.proto;
            source_port = snap_reg.sport;
            dst_port    = snap_reg.dport;
            pay_offset  = snap_reg.pay;
            last_result = (snap_reg.status != lhp_pkg::ST_OK);
        end
        else if (seq_reg <= n_words)
        begin
            idx        = addr_seq[1:0];
            kind       = lhp_pkg::KIND_SRC;
            word_index = idx;
            addr_word  = snap_reg.src[idx];
        end
        else
        begin
            idx         = dst_seq[1:0];
            kind        = lhp_pkg::KIND_DST;
            word_index  = idx;
            addr_word   = snap_reg.dst[idx];
            last_result = (seq_reg == {n_words[2:0], 1'b0});
        end
    end

    assign out_valid = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        seq_next  = seq_reg;
        if (out_acc)
        begin
            seq_next = seq_reg + 4'd1;
            if (last_result)
                busy_next = 1'b0;
        end
        if (in_acc && frame_end)
        begin
            busy_next = 1'b1;
            seq_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_kind_reg       <= lhp_pkg::LINK_ETHERNET;
            byte_count_reg      <= 16'd0;
            net_type_reg        <= 16'd0;
            net_start_reg       <= 8'd0;
            transport_start_reg <= 8'd0;
            payload_start_reg   <= 8'd0;
            next_proto_reg      <= 8'd0;
            port_src_reg        <= 16'd0;
            port_dst_reg        <= 16'd0;
            src_words_reg       <= '0;
            dst_words_reg       <= '0;
            busy_reg            <= 1'b0;
            seq_reg             <= 4'd0;
        end
        else
        begin
            if (cfg_write_en)
                link_kind_reg <= cfg_write_data;
            if (in_acc)
            begin
                byte_count_reg      <= byte_count_next;
                net_type_reg        <= net_type_next;
                net_start_reg       <= net_start_next;
                transport_start_reg <= transport_start_next;
                payload_start_reg   <= payload_start_next;
                next_proto_reg      <= next_proto_next;
                port_src_reg        <= port_src_next;
                port_dst_reg        <= port_dst_next;
                src_words_reg       <= src_words_next;
                dst_words_reg       <= dst_words_next;
            end
            busy_reg <= busy_next;
            seq_reg  <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && frame_end)
            snap_reg <= snap_next;
    end

    // a queued frame keeps offering items until its last one is taken
    a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |=> out_valid)
        else $error("result queue dropped before last item");

    // stall only guards a final byte against a busy queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (frame_end && busy_reg))
        else $error("input stalled without cause");

    // sequence never runs past nine items
    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (seq_reg <= 4'd8))
        else $error("result sequence out of range");

    // a failed frame yields only its status item
    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seq_reg == 4'd0 && status != lhp_pkg::ST_OK) |-> last_result)
        else $error("failed frame not closed by status item");

    // taking a non-final item advances to the next one
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !last_result) |=> (seq_reg == $past(seq_reg) + 4'd1))
        else $error("result sequence did not advance");

endmodule
